// ===== rtl/core/crdg_pkg.sv =====
// Package for the crop, downscale and grayscale block.
// Holds the register indexes, reset values, beat types and the luminance weight function.
// No dependencies; used by crdg_div and crop_downscale_grayscale.
package crdg_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_GRAY   = 2'd2;

    localparam logic [7:0] RST_TARGET_SIZE   = 8'd96;
    localparam logic [7:0] RST_TARGET_HEIGHT = 8'd96;

    // Luminance weights, scaled by 10000.
    localparam int WEIGHT_W = 22;
    localparam int SUM_W    = 24;
    localparam logic [WEIGHT_W-1:0] W_RED   = 22'd2126;
    localparam logic [WEIGHT_W-1:0] W_GREEN = 22'd7152;
    localparam logic [WEIGHT_W-1:0] W_BLUE  = 22'd722;
    localparam logic [WEIGHT_W-1:0] W_GRAY  = 22'd10000;

    // sum / 40000 = (sum >> 6) / 625, and x / 625 = (x * 214749) >> 27 for x below 2^18.
    localparam int RECIP_PRE_SHIFT = 6;
    localparam int RECIP_IN_W      = SUM_W - RECIP_PRE_SHIFT;
    localparam int RECIP_SHIFT     = 27;
    localparam int RECIP_PROD_W    = 36;
    localparam logic [RECIP_PROD_W-1:0] RECIP_MUL = 36'd214749;

    // Output queue depth.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef struct packed {
        logic        frame_done;
        logic [15:0] out_index;
        logic [7:0]  gray_value;
    } t_out_beat;

    // Luminance of one source pixel, times 10000.
    function automatic logic [WEIGHT_W-1:0] sample_weight(input logic [15:0] px,
                                                          input logic       is_gray);
        logic [WEIGHT_W-1:0] r8;
        logic [WEIGHT_W-1:0] g8;
        logic [WEIGHT_W-1:0] b8;
        r8 = WEIGHT_W'({px[15:11], 3'b000});
        g8 = WEIGHT_W'({px[10:5], 2'b00});
        b8 = WEIGHT_W'({px[4:0], 3'b000});
        if (is_gray) begin
            return WEIGHT_W'(px[7:0]) * W_GRAY;
        end
        return W_RED * r8 + W_GREEN * g8 + W_BLUE * b8;
    endfunction

endpackage

// ===== rtl/core/crdg_div.sv =====
// Bit-serial restoring divider: a DW-bit dividend by an 8-bit divisor, one bit per cycle.
// Depends on crdg_pkg for the status struct.
module crdg_div #(
    parameter int DW = 18
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DW-1:0]     i_dividend,
    input  logic [7:0]        i_divisor,
    output logic [DW-1:0]     o_quotient,
    output logic [7:0]        o_remainder,
    output crdg_pkg::t_div_stat o_stat
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    r_quo;
    logic [8:0]       r_rem;
    logic [7:0]       r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [8:0]       shifted;
    logic             fits;

    assign shifted = {r_rem[7:0], r_quo[DW-1]};
    assign fits    = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], fits};
            r_rem <= fits ? (shifted - {1'b0, r_div}) : shifted;
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem[7:0];
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== rtl/core/crop_downscale_grayscale.sv =====
// Top level of the crop, box-downscale and grayscale converter for a raster pixel stream.
// Depends on crdg_pkg and crdg_div.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+------------------------------------------
//  s       | in        | i_s_tvalid / o_s_tready    | tdata: pixel[15:0]; tuser: frame_start
//  m       | out       | o_m_tvalid / i_m_tready    | tdata: gray_value[7:0], out_index[23:8];
//          |           |                            | tlast: frame_done
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | index: register, data: value
//
// One pixel beat is accepted per cycle while the block is not recomputing its step constants.
// Results pass the stage B and stage C registers into a four-entry queue, and the input
// also stalls when that queue and the results in flight could fill it.
// After reset and after every write of target_size, a serial divider recomputes the column and
// row positions and step sizes in four divisions, during which no pixel and no configuration
// beat is taken.
// The row store holds no reset value; row 0 of every frame fills it before any use.
module crop_downscale_grayscale #(
    parameter int SRC_WIDTH   = 320,
    parameter int SRC_HEIGHT  = 240,
    parameter int CROP_LEFT   = 40,
    parameter int CROP_MARGIN = 120
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Pixel stream.
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [15:0]                    i_s_tdata,   // [15:0] pixel
    input  logic [0:0]                     i_s_tuser,   // [0] frame_start
    // Result stream.
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [23:0]                    o_m_tdata,   // [7:0] gray_value, [23:8] out_index
    output logic                           o_m_tlast,   // frame_done
    // Configuration writes.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [crdg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);

    localparam int CROP_W       = SRC_WIDTH - CROP_MARGIN;
    localparam int SIZE_LIM_RAW = (CROP_W < SRC_HEIGHT - 1) ? CROP_W : SRC_HEIGHT - 1;
    localparam int SIZE_LIM     = (SIZE_LIM_RAW > 255) ? 255 : SIZE_LIM_RAW;
    localparam int COL_W        = $clog2(SRC_WIDTH);
    localparam int ROW_W        = $clog2(SRC_HEIGHT);
    localparam int IDX_W        = $clog2(CROP_W + 1);
    localparam int AW           = $clog2(CROP_W);
    localparam int STEP_MAX     = (CROP_W > SRC_HEIGHT) ? CROP_W : SRC_HEIGHT;
    localparam int DIV_W        = $clog2(255 * STEP_MAX + 1);
    localparam int CMP_W        = ((DIV_W > COL_W) ? DIV_W : COL_W) + 1;
    localparam int WW           = crdg_pkg::WEIGHT_W;

    // Step-constant sequencer states and division jobs.
    localparam logic [1:0] SEQ_IDLE  = 2'd0;
    localparam logic [1:0] SEQ_ISSUE = 2'd1;
    localparam logic [1:0] SEQ_WAIT  = 2'd2;
    localparam logic [1:0] JOB_COL   = 2'd0;
    localparam logic [1:0] JOB_ROW   = 2'd1;
    localparam logic [1:0] JOB_CSTEP = 2'd2;
    localparam logic [1:0] JOB_RSTEP = 2'd3;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [7:0] r_size;
    logic [7:0] r_height;
    logic       r_gray;
    logic       cfg_fire;
    logic [7:0] size_eff;
    logic [7:0] rows_kept;

    assign cfg_fire  = i_cfg_valid && o_cfg_ready;
    assign size_eff  = (r_size > SIZE_LIM) ? 8'(SIZE_LIM) : r_size;
    assign rows_kept = (r_height < size_eff) ? r_height : size_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= crdg_pkg::RST_TARGET_SIZE;
            r_height <= crdg_pkg::RST_TARGET_HEIGHT;
            r_gray   <= 1'b0;
        end else if (cfg_fire) begin
            unique case (i_cfg_index)
                crdg_pkg::CFG_TARGET_SIZE:   r_size   <= i_cfg_data;
                crdg_pkg::CFG_TARGET_HEIGHT: r_height <= i_cfg_data;
                crdg_pkg::CFG_SOURCE_GRAY:   r_gray   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Raster and output position state.
    // The sample column of output x is CROP_LEFT + floor(x*CROP_W/size); it is kept as a
    // quotient and remainder and stepped by CROP_W/size. Rows work the same with SRC_HEIGHT.
    // ------------------------------------------------------------------
    logic [COL_W-1:0] r_src_col;
    logic [ROW_W-1:0] r_src_row;
    logic [WW-1:0]    r_left;
    logic [WW-1:0]    r_edge;     // row store entry CROP_W, kept apart so one write port suffices
    logic [7:0]       r_ocol;
    logic [7:0]       r_orow;
    logic [DIV_W-1:0] r_col_q;
    logic [7:0]       r_col_rem;
    logic [DIV_W-1:0] r_row_q;
    logic [7:0]       r_row_rem;
    logic [DIV_W-1:0] r_cstep_q;
    logic [7:0]       r_cstep_rem;
    logic [DIV_W-1:0] r_rstep_q;
    logic [7:0]       r_rstep_rem;

    logic [COL_W-1:0] n_src_col;
    logic [ROW_W-1:0] n_src_row;
    logic [WW-1:0]    n_left;
    logic [WW-1:0]    n_edge;
    logic [7:0]       n_ocol;
    logic [7:0]       n_orow;
    logic [DIV_W-1:0] n_col_q;
    logic [7:0]       n_col_rem;
    logic [DIV_W-1:0] n_row_q;
    logic [7:0]       n_row_rem;

    // ------------------------------------------------------------------
    // Step-constant sequencer around the shared serial divider.
    // ------------------------------------------------------------------
    logic [1:0]           r_seq;
    logic [1:0]           r_job;
    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic [DIV_W-1:0]     div_quo;
    logic [7:0]           div_rem;
    crdg_pkg::t_div_stat  div_stat;
    logic                 busy;

    assign busy      = (r_seq != SEQ_IDLE);
    assign div_start = (r_seq == SEQ_ISSUE);

    always_comb begin
        unique case (r_job)
            JOB_COL:   div_dividend = DIV_W'(DIV_W'(r_ocol) * DIV_W'(CROP_W));
            JOB_ROW:   div_dividend = DIV_W'(DIV_W'(r_orow) * DIV_W'(SRC_HEIGHT));
            JOB_CSTEP: div_dividend = DIV_W'(CROP_W);
            default:   div_dividend = DIV_W'(SRC_HEIGHT);
        endcase
    end

    crdg_div #(
        .DW (DIV_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (size_eff),
        .o_quotient  (div_quo),
        .o_remainder (div_rem),
        .o_stat      (div_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= SEQ_ISSUE;
            r_job <= JOB_COL;
        end else begin
            unique case (r_seq)
                SEQ_IDLE: begin
                    if (cfg_fire && i_cfg_index == crdg_pkg::CFG_TARGET_SIZE) begin
                        r_seq <= SEQ_ISSUE;
                        r_job <= JOB_COL;
                    end
                end
                SEQ_ISSUE: r_seq <= SEQ_WAIT;
                SEQ_WAIT: begin
                    if (div_stat.done) begin
                        if (r_job == JOB_RSTEP) begin
                            r_seq <= SEQ_IDLE;
                        end else begin
                            r_seq <= SEQ_ISSUE;
                            r_job <= r_job + 2'd1;
                        end
                    end
                end
                default: r_seq <= SEQ_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage A: accept a pixel, decide on a result, update the raster state and
    // read / write the row store.
    // ------------------------------------------------------------------
    logic              s_fire;
    logic [3:0]        occupancy;
    logic              a_start;
    logic [COL_W-1:0]  a_col;
    logic [ROW_W-1:0]  a_row;
    logic [WW-1:0]     a_left;
    logic [7:0]        a_ocol;
    logic [7:0]        a_orow;
    logic [DIV_W-1:0]  a_col_q;
    logic [7:0]        a_col_rem;
    logic [DIV_W-1:0]  a_row_q;
    logic [7:0]        a_row_rem;
    logic [WW-1:0]     a_w;
    logic              a_crop;
    logic [IDX_W-1:0]  a_idx;
    logic              a_is_edge;
    logic              a_emit;
    logic [8:0]        a_ocol_inc;
    logic [8:0]        col_rem_sum;
    logic [8:0]        row_rem_sum;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    logic              r_b_valid;
    logic              r_c_valid;
    logic              r_b_emit;
    logic [crdg_pkg::Q_CNT_W-1:0] r_q_count;

    // Room for this beat's result is reserved before it is taken.
    assign occupancy  = 4'(r_q_count) + 4'(r_b_valid && r_b_emit) + 4'(r_c_valid);
    assign o_s_tready = !busy && (occupancy < 4'(crdg_pkg::Q_DEPTH));
    assign o_cfg_ready = !busy;
    assign s_fire     = i_s_tvalid && o_s_tready;

    always_comb begin
        a_start   = i_s_tuser[0];
        a_col     = a_start ? '0 : r_src_col;
        a_row     = a_start ? '0 : r_src_row;
        a_left    = a_start ? '0 : r_left;
        a_ocol    = a_start ? '0 : r_ocol;
        a_orow    = a_start ? '0 : r_orow;
        a_col_q   = a_start ? '0 : r_col_q;
        a_col_rem = a_start ? '0 : r_col_rem;
        a_row_q   = a_start ? '0 : r_row_q;
        a_row_rem = a_start ? '0 : r_row_rem;
        a_w       = crdg_pkg::sample_weight(i_s_tdata, r_gray);

        a_crop    = (a_col >= COL_W'(CROP_LEFT))
                    && ({1'b0, a_col} <= (COL_W + 1)'(CROP_LEFT + CROP_W));
        a_idx     = IDX_W'(a_col - COL_W'(CROP_LEFT));
        a_is_edge = (a_idx == IDX_W'(CROP_W));

        // The box closes at its bottom-right sample.
        a_emit = a_crop && (a_idx != '0) && (size_eff != '0)
                 && (a_orow < rows_kept) && (a_ocol < size_eff)
                 && (CMP_W'(a_col) == CMP_W'(CROP_LEFT) + CMP_W'(a_col_q) + CMP_W'(1))
                 && (CMP_W'(a_row) == CMP_W'(a_row_q) + CMP_W'(1));

        mem_we    = s_fire && a_crop && (a_idx != '0);
        mem_waddr = AW'(a_idx - IDX_W'(1));
        mem_re    = s_fire && a_crop && !a_is_edge;
        mem_raddr = AW'(a_idx);

        a_ocol_inc  = {1'b0, a_ocol} + 9'd1;
        col_rem_sum = {1'b0, a_col_rem} + {1'b0, r_cstep_rem};
        row_rem_sum = {1'b0, a_row_rem} + {1'b0, r_rstep_rem};
        col_inc     = {1'b0, a_col} + (COL_W + 1)'(1);
        row_inc     = {1'b0, a_row} + (ROW_W + 1)'(1);

        n_src_col = r_src_col;
        n_src_row = r_src_row;
        n_left    = r_left;
        n_edge    = r_edge;
        n_ocol    = r_ocol;
        n_orow    = r_orow;
        n_col_q   = r_col_q;
        n_col_rem = r_col_rem;
        n_row_q   = r_row_q;
        n_row_rem = r_row_rem;

        if (s_fire) begin
            n_left    = a_left;
            n_ocol    = a_ocol;
            n_orow    = a_orow;
            n_col_q   = a_col_q;
            n_col_rem = a_col_rem;
            n_row_q   = a_row_q;
            n_row_rem = a_row_rem;

            if (a_crop) begin
                n_left = a_w;
                if (a_is_edge) begin
                    n_edge = a_w;
                end
            end

            if (a_emit) begin
                if (a_ocol_inc >= {1'b0, size_eff}) begin
                    n_ocol    = '0;
                    n_col_q   = '0;
                    n_col_rem = '0;
                    n_orow    = a_orow + 8'd1;
                    if (row_rem_sum >= {1'b0, size_eff}) begin
                        n_row_q   = a_row_q + r_rstep_q + DIV_W'(1);
                        n_row_rem = 8'(row_rem_sum - {1'b0, size_eff});
                    end else begin
                        n_row_q   = a_row_q + r_rstep_q;
                        n_row_rem = row_rem_sum[7:0];
                    end
                end else begin
                    n_ocol = a_ocol_inc[7:0];
                    if (col_rem_sum >= {1'b0, size_eff}) begin
                        n_col_q   = a_col_q + r_cstep_q + DIV_W'(1);
                        n_col_rem = 8'(col_rem_sum - {1'b0, size_eff});
                    end else begin
                        n_col_q   = a_col_q + r_cstep_q;
                        n_col_rem = col_rem_sum[7:0];
                    end
                end
            end

            // Raster advance; the end of the frame wraps into an implicit new one.
            n_src_col = col_inc[COL_W-1:0];
            n_src_row = a_row;
            if (col_inc >= (COL_W + 1)'(SRC_WIDTH)) begin
                n_src_col = '0;
                n_src_row = row_inc[ROW_W-1:0];
                if (row_inc >= (ROW_W + 1)'(SRC_HEIGHT)) begin
                    n_src_row = '0;
                    n_left    = '0;
                    n_ocol    = '0;
                    n_orow    = '0;
                    n_col_q   = '0;
                    n_col_rem = '0;
                    n_row_q   = '0;
                    n_row_rem = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col <= '0;
            r_src_row <= '0;
            r_left    <= '0;
            r_ocol    <= '0;
            r_orow    <= '0;
            r_col_q   <= '0;
            r_col_rem <= '0;
            r_row_q   <= '0;
            r_row_rem <= '0;
        end else if (r_seq == SEQ_WAIT && div_stat.done && r_job == JOB_COL) begin
            r_col_q   <= div_quo;
            r_col_rem <= div_rem;
        end else if (r_seq == SEQ_WAIT && div_stat.done && r_job == JOB_ROW) begin
            r_row_q   <= div_quo;
            r_row_rem <= div_rem;
        end else begin
            r_src_col <= n_src_col;
            r_src_row <= n_src_row;
            r_left    <= n_left;
            r_ocol    <= n_ocol;
            r_orow    <= n_orow;
            r_col_q   <= n_col_q;
            r_col_rem <= n_col_rem;
            r_row_q   <= n_row_q;
            r_row_rem <= n_row_rem;
        end
    end

    // Step sizes and the edge entry carry no reset: the sequencer runs after every reset,
    // and the edge entry is written by row 0 before it is read.
    always_ff @(posedge i_clk) begin
        r_edge <= n_edge;
        if (r_seq == SEQ_WAIT && div_stat.done && r_job == JOB_CSTEP) begin
            r_cstep_q   <= div_quo;
            r_cstep_rem <= div_rem;
        end
        if (r_seq == SEQ_WAIT && div_stat.done && r_job == JOB_RSTEP) begin
            r_rstep_q   <= div_quo;
            r_rstep_rem <= div_rem;
        end
    end

    // Row store: weights of the row above, columns 0 .. CROP_W-1 of the crop.
    // Each pixel writes its left neighbour one entry behind the entry it reads.
    logic [WW-1:0] r_row_mem [CROP_W];
    logic [WW-1:0] r_mem_rdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_row_mem[mem_waddr] <= a_left;
        end
        if (mem_re) begin
            r_mem_rdata <= r_row_mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Stage B: gather the four samples and the output index.
    // The upper-left sample is the upper-right one read for the previous crop pixel.
    // ------------------------------------------------------------------
    logic [WW-1:0] r_b_left;
    logic [WW-1:0] r_b_w;
    logic          r_b_edge;
    logic [WW-1:0] r_b_edge_val;
    logic [7:0]    r_b_ocol;
    logic [7:0]    r_b_orow;
    logic [7:0]    r_b_size;
    logic [7:0]    r_b_rows;
    logic [WW-1:0] r_prev_here;
    logic [WW-1:0] b_here;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_emit  <= 1'b0;
        end else begin
            r_b_valid <= s_fire && a_crop;
            r_b_emit  <= a_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_left     <= a_left;
        r_b_w        <= a_w;
        r_b_edge     <= a_is_edge;
        r_b_edge_val <= r_edge;
        r_b_ocol     <= a_ocol;
        r_b_orow     <= a_orow;
        r_b_size     <= size_eff;
        r_b_rows     <= rows_kept;
        if (r_b_valid) begin
            r_prev_here <= b_here;
        end
    end

    assign b_here = r_b_edge ? r_b_edge_val : r_mem_rdata;

    // ------------------------------------------------------------------
    // Stage C: divide the box sum by 40000 and flag the frame's last result.
    // ------------------------------------------------------------------
    logic [crdg_pkg::SUM_W-1:0]        r_c_sum;
    logic [15:0]                       r_c_oidx;
    logic [15:0]                       r_c_last;
    logic [crdg_pkg::RECIP_PROD_W-1:0] c_prod;
    crdg_pkg::t_out_beat               c_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid && r_b_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_sum  <= crdg_pkg::SUM_W'(r_prev_here) + crdg_pkg::SUM_W'(b_here)
                    + crdg_pkg::SUM_W'(r_b_left) + crdg_pkg::SUM_W'(r_b_w);
        r_c_oidx <= 16'(r_b_orow * r_b_size) + 16'(r_b_ocol);
        r_c_last <= 16'(r_b_rows * r_b_size) - 16'd1;
    end

    assign c_prod = crdg_pkg::RECIP_PROD_W'(r_c_sum[crdg_pkg::SUM_W-1:crdg_pkg::RECIP_PRE_SHIFT])
                    * crdg_pkg::RECIP_MUL;

    always_comb begin
        c_beat.gray_value = 8'(c_prod >> crdg_pkg::RECIP_SHIFT);
        c_beat.out_index  = r_c_oidx;
        c_beat.frame_done = (r_c_oidx == r_c_last);
    end

    // ------------------------------------------------------------------
    // Output queue.
    // ------------------------------------------------------------------
    crdg_pkg::t_out_beat              r_q [crdg_pkg::Q_DEPTH];
    logic [crdg_pkg::Q_PTR_W-1:0]     r_q_wr;
    logic [crdg_pkg::Q_PTR_W-1:0]     r_q_rd;
    logic                             q_pop;
    crdg_pkg::t_out_beat              q_head;

    assign q_pop  = o_m_tvalid && i_m_tready;
    assign q_head = r_q[r_q_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr    <= '0;
            r_q_rd    <= '0;
            r_q_count <= '0;
        end else begin
            if (r_c_valid) begin
                r_q_wr <= r_q_wr + 1'b1;
            end
            if (q_pop) begin
                r_q_rd <= r_q_rd + 1'b1;
            end
            r_q_count <= r_q_count + crdg_pkg::Q_CNT_W'(r_c_valid)
                         - crdg_pkg::Q_CNT_W'(q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_c_valid) begin
            r_q[r_q_wr] <= c_beat;
        end
    end

    assign o_m_tvalid = (r_q_count != '0);
    assign o_m_tdata  = {q_head.out_index, q_head.gray_value};
    assign o_m_tlast  = q_head.frame_done;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid |-> (r_q_count < crdg_pkg::Q_CNT_W'(crdg_pkg::Q_DEPTH)) || q_pop)
        else $error("result pushed into a full output queue");

    a_result_follows_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid |-> $past(r_b_valid && r_b_emit))
        else $error("result stage loaded without an emitting pixel");

    a_size_write_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_fire && i_cfg_index == crdg_pkg::CFG_TARGET_SIZE) |=> !o_s_tready)
        else $error("pixels accepted before step constants were recomputed");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

endmodule
